// File: sv/utf8e_pkg.sv
package utf8e_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int BYTE_W      = 8;
   localparam int CAP_W       = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int UNIT_MAX    = 6;
   localparam int UNIT_IDX_W  = $clog2(UNIT_MAX);
   localparam int PEND_DEPTH  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY    = 1'd1;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd4096;

   // unit that the datapath loads into its emit buffer
   typedef enum logic [1:0] {
      UNIT_SEQ,
      UNIT_REP,
      UNIT_ESC
   } utf8e_unit_sel_type;

   typedef struct packed {
      logic               take;
      logic               pend_clear;
      logic               pend_push;
      logic               flush_start;
      logic               flush_dec;
      logic               load_unit;
      utf8e_unit_sel_type unit_sel;
      logic               set_stop;
      logic               emit_byte;
      logic               emit_end;
   } utf8e_cmd_type;

   typedef struct packed {
      logic in_valid;
      logic last;
      logic stop;
      logic pcnt_zero;
      logic cont;
      logic complete;
      logic zero_byte;
      logic ascii;
      logic lead;
      logic fits;
      logic unit_last;
      logic flush_zero;
      logic out_free;
   } utf8e_stat_type;

endpackage

// File: sv/utf8e_if.sv
interface utf8e_req_if;
   import utf8e_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              last;
   modport source (output valid, output in_byte, output last, input ready);
   modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface utf8e_rsp_if;
   import utf8e_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [BYTE_W-1:0]      out_byte;
   logic                   is_end;
   logic [LENGTH_BITS-1:0] total_length;
   modport source (output valid, output out_byte, output is_end, output total_length,
                   input ready);
   modport sink   (input valid, input out_byte, input is_end, input total_length,
                   output ready);
endinterface

// File: sv/utf8_sanitizing_json_escaper.sv
// channel | dir | handshake          | payload
// req_ch  | in  | valid / ready      | in_byte[7:0], last
// rsp_ch  | out | valid / ready      | out_byte[7:0], is_end, total_length[15:0]
// csr_*   | in  | csr_we, no ready   | csr_index[0] (0 escape_mode, 1 capacity), csr_wdata[15:0]
//
// One source byte at a time: ready is high only while the controller is idle.
// A byte runs through IDLE, DECIDE, FRESH (skipped when it completes a held sequence),
// CHECK, EMIT once per unit byte and POST; a new lead or continuation that is only held,
// or an ignored byte, goes to POST without emitting; a flush loads one replacement per held byte.
// The emit loop (one output beat per cycle while rsp_ch is not stalled) sets the rate.
// Reset (synchronous, active high) clears control state and sets capacity 4096.
// A stalled rsp_ch holds the emit loop; the output register keeps one beat.
module utf8_sanitizing_json_escaper (
   input  logic                              clock,
   input  logic                              reset,
   utf8e_req_if.sink                         req_ch,
   utf8e_rsp_if.source                       rsp_ch,
   input  logic                              csr_we,
   input  logic [utf8e_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [utf8e_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import utf8e_pkg::*;

   utf8e_cmd_type  cmd;    // controller -> datapath
   utf8e_stat_type stat;   // datapath -> controller

   // input beat taken only in the idle state
   assign req_ch.ready = cmd.take;

   utf8e_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // datapath: pending bytes, unit buffer, counters, output register, config
   utf8e_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_valid   (req_ch.valid),
      .in_byte    (req_ch.in_byte),
      .in_last    (req_ch.last),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_byte   (rsp_ch.out_byte),
      .out_is_end (rsp_ch.is_end),
      .out_total  (rsp_ch.total_length),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

// File: sv/utf8e_dp.sv
module utf8e_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  utf8e_pkg::utf8e_cmd_type               cmd,
   output utf8e_pkg::utf8e_stat_type              stat,
   input  logic                                   in_valid,
   input  logic [utf8e_pkg::BYTE_W-1:0]           in_byte,
   input  logic                                   in_last,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [utf8e_pkg::BYTE_W-1:0]           out_byte,
   output logic                                   out_is_end,
   output logic [utf8e_pkg::LENGTH_BITS-1:0]      out_total,
   input  logic                                   csr_we,
   input  logic [utf8e_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [utf8e_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import utf8e_pkg::*;

   localparam int CMP_W = LENGTH_BITS + 1;

   logic                   mode_ff, mode_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic [BYTE_W-1:0]      byte_ff;
   logic                   last_ff;
   logic [BYTE_W-1:0]      pend_ff [PEND_DEPTH];
   logic [1:0]             pcnt_ff, pcnt_in;
   logic [LENGTH_BITS-1:0] wcnt_ff, wcnt_in;
   logic                   stop_ff, stop_in;
   logic [1:0]             flush_ff, flush_in;
   logic [BYTE_W-1:0]      unit_ff [UNIT_MAX];
   logic [2:0]             ulen_ff;
   logic [UNIT_IDX_W-1:0]  uidx_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]      out_byte_ff;
   logic                   out_end_ff;
   logic [LENGTH_BITS-1:0] out_len_ff;

   logic                   accept;
   logic [BYTE_W-1:0]      esc_bytes [UNIT_MAX];
   logic [2:0]             esc_len;
   logic [BYTE_W-1:0]      seq_bytes [UNIT_MAX];
   logic [BYTE_W-1:0]      ld_bytes  [UNIT_MAX];
   logic [2:0]             ld_len;

   function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
      if (b >= 8'hC2 && b <= 8'hDF) return 3'd2;
      if (b >= 8'hE0 && b <= 8'hEF) return 3'd3;
      if (b >= 8'hF0 && b <= 8'hF4) return 3'd4;
      return 3'd0;
   endfunction

   // second byte bounds tighten for E0, ED, F0 and F4 leads
   function automatic logic continues(input logic [BYTE_W-1:0] lead, input logic [1:0] pos,
                                      input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      lo = 8'h80;
      hi = 8'hBF;
      if (pos == 2'd1) begin
         if (lead == 8'hE0)      lo = 8'hA0;
         else if (lead == 8'hED) hi = 8'h9F;
         else if (lead == 8'hF0) lo = 8'h90;
         else if (lead == 8'hF4) hi = 8'h8F;
      end
      return (b >= lo) && (b <= hi);
   endfunction

   function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
   endfunction

   assign accept = cmd.take & in_valid;

   // escape unit for an ASCII byte
   always_comb begin
      esc_bytes = '{default: '0};
      esc_bytes[0] = 8'h5C;
      esc_len = 3'd2;
      if (mode_ff) begin
         esc_bytes[0] = byte_ff;
         esc_len = 3'd1;
      end else if (byte_ff == 8'h22 || byte_ff == 8'h5C) begin
         esc_bytes[1] = byte_ff;
      end else if (byte_ff == 8'h0A) begin
         esc_bytes[1] = 8'h6E;
      end else if (byte_ff == 8'h0D) begin
         esc_bytes[1] = 8'h72;
      end else if (byte_ff == 8'h09) begin
         esc_bytes[1] = 8'h74;
      end else if (byte_ff < 8'h20) begin
         esc_bytes[1] = 8'h75;
         esc_bytes[2] = 8'h30;
         esc_bytes[3] = 8'h30;
         esc_bytes[4] = hex_digit(byte_ff[7:4]);
         esc_bytes[5] = hex_digit(byte_ff[3:0]);
         esc_len = 3'd6;
      end else begin
         esc_bytes[0] = byte_ff;
         esc_len = 3'd1;
      end
   end

   // held bytes followed by the completing byte
   always_comb begin
      seq_bytes = '{default: '0};
      seq_bytes[0] = pend_ff[0];
      seq_bytes[1] = (pcnt_ff == 2'd1) ? byte_ff : pend_ff[1];
      seq_bytes[2] = (pcnt_ff == 2'd2) ? byte_ff : pend_ff[2];
      seq_bytes[3] = byte_ff;
   end

   always_comb begin
      ld_bytes = '{default: '0};
      ld_len = 3'd3;
      case (cmd.unit_sel)
         UNIT_SEQ: begin
            ld_bytes = seq_bytes;
            ld_len = {1'b0, pcnt_ff} + 3'd1;
         end
         UNIT_ESC: begin
            ld_bytes = esc_bytes;
            ld_len = esc_len;
         end
         default: begin
            ld_bytes[0] = 8'hEF;
            ld_bytes[1] = 8'hBF;
            ld_bytes[2] = 8'hBD;
            ld_len = 3'd3;
         end
      endcase
   end

   always_comb begin
      stat.in_valid   = in_valid;
      stat.last       = last_ff;
      stat.stop       = stop_ff;
      stat.pcnt_zero  = (pcnt_ff == 2'd0);
      stat.cont       = continues(pend_ff[0], pcnt_ff, byte_ff);
      stat.complete   = ({1'b0, pcnt_ff} + 3'd1) >= lead_len(pend_ff[0]);
      stat.zero_byte  = (byte_ff == 8'h00);
      stat.ascii      = (byte_ff < 8'h80);
      stat.lead       = (lead_len(byte_ff) != 3'd0);
      // unit fits when written + len <= capacity - 1; capacity zero never fits
      stat.fits       = ({1'b0, wcnt_ff} + CMP_W'(ulen_ff) + CMP_W'(1))
                        <= CMP_W'(cap_ff);
      stat.unit_last  = (uidx_ff == (ulen_ff - 3'd1));
      stat.flush_zero = (flush_ff == 2'd0);
      stat.out_free   = !out_valid_ff || out_ready;
   end

   always_comb begin
      mode_in = mode_ff;
      cap_in = cap_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ESCAPE_MODE: mode_in = csr_wdata[0];
            CSR_CAPACITY:    cap_in  = csr_wdata[CAP_W-1:0];
            default: ;
         endcase
      end

      pcnt_in = pcnt_ff;
      if (cmd.pend_clear || cmd.flush_start || cmd.emit_end) pcnt_in = 2'd0;
      else if (cmd.pend_push) pcnt_in = pcnt_ff + 2'd1;

      flush_in = flush_ff;
      if (cmd.flush_start)    flush_in = pcnt_ff;
      else if (cmd.flush_dec) flush_in = flush_ff - 2'd1;

      stop_in = stop_ff;
      if (cmd.emit_end)      stop_in = 1'b0;
      else if (cmd.set_stop) stop_in = 1'b1;

      wcnt_in = wcnt_ff;
      if (cmd.emit_end)       wcnt_in = '0;
      else if (cmd.emit_byte) wcnt_in = wcnt_ff + LENGTH_BITS'(1);

      out_valid_in = out_valid_ff;
      if (cmd.emit_byte || cmd.emit_end) out_valid_in = 1'b1;
      else if (out_ready)                out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         cap_ff       <= CAPACITY_RESET;
         pcnt_ff      <= 2'd0;
         flush_ff     <= 2'd0;
         stop_ff      <= 1'b0;
         wcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         cap_ff       <= cap_in;
         pcnt_ff      <= pcnt_in;
         flush_ff     <= flush_in;
         stop_ff      <= stop_in;
         wcnt_ff      <= wcnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= in_byte;
         last_ff <= in_last;
      end
      if (cmd.pend_push) pend_ff[pcnt_ff] <= byte_ff;
      if (cmd.load_unit) begin
         unit_ff <= ld_bytes;
         ulen_ff <= ld_len;
         uidx_ff <= '0;
      end else if (cmd.emit_byte) begin
         uidx_ff <= uidx_ff + UNIT_IDX_W'(1);
      end
      if (cmd.emit_byte) begin
         out_byte_ff <= unit_ff[uidx_ff];
         out_end_ff  <= 1'b0;
         out_len_ff  <= wcnt_ff + LENGTH_BITS'(1);
      end else if (cmd.emit_end) begin
         out_byte_ff <= '0;
         out_end_ff  <= 1'b1;
         out_len_ff  <= wcnt_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_byte   = out_byte_ff;
   assign out_is_end = out_end_ff;
   assign out_total  = out_len_ff;

`ifndef ASSERT_OFF
   a_stop_clears_pend: assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> pcnt_ff == 2'd0)
      else $error("bytes held while output stopped");
   a_emit_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_byte |=> wcnt_ff == LENGTH_BITS'($past(wcnt_ff) + LENGTH_BITS'(1)))
      else $error("written count not advanced by one beat");
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_byte || cmd.emit_end) |=> out_valid_ff && (out_end_ff == $past(cmd.emit_end)))
      else $error("emitted beat not in output register");
`endif

endmodule

// File: sv/utf8e_ctrl.sv
module utf8e_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  utf8e_pkg::utf8e_stat_type stat,
   output utf8e_pkg::utf8e_cmd_type  cmd
);
   import utf8e_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_FRESH,
      S_FLUSH,
      S_CHECK,
      S_EMIT,
      S_POST,
      S_END
   } state_type;

   state_type state_ff, state_in;
   logic      ret_flush_ff, ret_flush_in;   // unit done: back to FLUSH, else POST
   logic      tail_ff, tail_in;             // flush closes the string

   always_comb begin
      cmd = '0;
      cmd.unit_sel = UNIT_REP;
      state_in = state_ff;
      ret_flush_in = ret_flush_ff;
      tail_in = tail_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = 1'b1;
            if (stat.in_valid) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.stop) begin
               cmd.pend_clear = 1'b1;
               state_in = S_POST;
            end else if (stat.pcnt_zero) begin
               state_in = S_FRESH;
            end else if (stat.cont && stat.complete) begin
               cmd.load_unit = 1'b1;
               cmd.unit_sel = UNIT_SEQ;
               cmd.pend_clear = 1'b1;
               ret_flush_in = 1'b0;
               state_in = S_CHECK;
            end else if (stat.cont) begin
               cmd.pend_push = 1'b1;
               state_in = S_POST;
            end else begin
               cmd.flush_start = 1'b1;
               tail_in = 1'b0;
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (stat.flush_zero) begin
               state_in = tail_ff ? S_END : S_FRESH;
            end else begin
               cmd.load_unit = 1'b1;
               cmd.unit_sel = UNIT_REP;
               cmd.flush_dec = 1'b1;
               ret_flush_in = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_FRESH: begin
            ret_flush_in = 1'b0;
            if (stat.stop) begin
               state_in = S_POST;
            end else if (stat.zero_byte) begin
               cmd.set_stop = 1'b1;
               state_in = S_POST;
            end else if (stat.ascii) begin
               cmd.load_unit = 1'b1;
               cmd.unit_sel = UNIT_ESC;
               state_in = S_CHECK;
            end else if (stat.lead) begin
               cmd.pend_push = 1'b1;
               state_in = S_POST;
            end else begin
               cmd.load_unit = 1'b1;
               cmd.unit_sel = UNIT_REP;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.stop || !stat.fits) begin
               cmd.set_stop = 1'b1;
               state_in = ret_flush_ff ? S_FLUSH : S_POST;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_byte = 1'b1;
               if (stat.unit_last) state_in = ret_flush_ff ? S_FLUSH : S_POST;
            end
         end
         S_POST: begin
            if (!stat.last) begin
               state_in = S_IDLE;
            end else if (!stat.stop && !stat.pcnt_zero) begin
               cmd.flush_start = 1'b1;
               tail_in = 1'b1;
               state_in = S_FLUSH;
            end else begin
               state_in = S_END;
            end
         end
         S_END: begin
            if (stat.out_free) begin
               cmd.emit_end = 1'b1;
               tail_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_flush_ff <= 1'b0;
         tail_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_flush_ff <= ret_flush_in;
         tail_ff      <= tail_in;
      end
   end

endmodule
